// ===== hw/rtl/ceu_pkg.sv =====
// Package for the composition enumerator: field widths, index commands and
// the command and status words between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package ceu_pkg;

	localparam int SIZE_W = 5;
	localparam int VAL_W  = 5;
	localparam int POS_W  = 4;

	// Index counter commands.
	localparam logic [2:0] IDX_HOLD   = 3'd0;
	localparam logic [2:0] IDX_CLR    = 3'd1;
	localparam logic [2:0] IDX_LASTM1 = 3'd2;
	localparam logic [2:0] IDX_INC    = 3'd3;
	localparam logic [2:0] IDX_DEC    = 3'd4;

	typedef struct packed {
		logic [2:0] idx_op;
		logic       fill_wr;
		logic       inc_wr;
		logic       refill_wr;
		logic       set_last;
		logic       out_part;
		logic       out_exh;
		logic       final_flag;
	} cmd_t;

	typedef struct packed {
		logic idx_zero;
		logic idx_at_last;
		logic last_zero;
		logic pref_lt_n;
		logic refill_go;
		logic fill_end;
		logic n_zero;
		logic n_gt1;
		logic p0_lt_n;
		logic out_free;
	} sts_t;

endpackage

// ===== hw/rtl/ceu_req_if.sv =====
// Request channel of the composition enumerator: valid, ready, restart flag.
// Depends on nothing.
`timescale 1ns / 1ps

interface ceu_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

// ===== hw/rtl/ceu_res_if.sv =====
// Result channel of the composition enumerator: one part per word.
// Depends on ceu_pkg for the field widths.
`timescale 1ns / 1ps

interface ceu_res_if;
	logic                        valid;
	logic                        ready;
	logic [ceu_pkg::VAL_W-1:0]   part_value;
	logic [ceu_pkg::POS_W-1:0]   part_position;
	logic                        last_part;
	logic                        final_composition;
	logic                        exhausted;

	modport source (output valid, output part_value, output part_position,
		output last_part, output final_composition, output exhausted, input ready);
	modport sink (input valid, input part_value, input part_position,
		input last_part, input final_composition, input exhausted, output ready);
endinterface

// ===== hw/rtl/ceu_dpath.sv =====
// Datapath of the composition enumerator: part and prefix-sum memories,
// index counter, size register and the output register. Depends on ceu_pkg.
`timescale 1ns / 1ps

module ceu_dpath #(
	parameter int MAX_SIZE = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [ceu_pkg::SIZE_W-1:0]  cfg_wr_data,
	input  ceu_pkg::cmd_t               cmd,
	output ceu_pkg::sts_t               sts,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [ceu_pkg::VAL_W-1:0]   res_value,
	output logic [ceu_pkg::POS_W-1:0]   res_position,
	output logic                        res_last,
	output logic                        res_final,
	output logic                        res_exhausted
);

	localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int CW = IW + ceu_pkg::SIZE_W + 1;

	logic [ceu_pkg::SIZE_W-1:0] size_q;
	logic [ceu_pkg::SIZE_W-1:0] n_eff;
	logic [IW-1:0]              idx_q;
	logic [IW-1:0]              last_q;
	logic [IW-1:0]              wr_addr;
	logic [ceu_pkg::SIZE_W-1:0] ps_q;
	logic [ceu_pkg::VAL_W-1:0]  p0_q;
	logic [ceu_pkg::VAL_W-1:0]  parts_mem [MAX_SIZE];
	logic [ceu_pkg::SIZE_W-1:0] pref_mem [MAX_SIZE];
	logic [ceu_pkg::VAL_W-1:0]  parts_rd_q;
	logic [ceu_pkg::SIZE_W-1:0] pref_rd_q;
	logic [ceu_pkg::VAL_W-1:0]  parts_wd;
	logic [ceu_pkg::SIZE_W-1:0] pref_wd;
	logic                       mem_we;
	logic [CW-1:0]              idx_ext;
	logic [CW-1:0]              n_ext;
	logic                       out_valid_q;

	// Sizes above the storage depth are clamped to it.
	assign n_eff = (CW'(size_q) > CW'(MAX_SIZE)) ? ceu_pkg::SIZE_W'(MAX_SIZE) : size_q;
	assign idx_ext = CW'(idx_q);
	assign n_ext = CW'(n_eff);

	always_comb begin
		sts.idx_zero    = (idx_q == '0);
		sts.idx_at_last = (idx_q == last_q);
		sts.last_zero   = (last_q == '0);
		sts.pref_lt_n   = (pref_rd_q < n_eff);
		sts.refill_go   = (ps_q < n_eff) && ((idx_ext + CW'(1)) < n_ext);
		sts.fill_end    = ((idx_ext + CW'(1)) >= n_ext);
		sts.n_zero      = (n_eff == '0);
		sts.n_gt1       = (n_eff > ceu_pkg::SIZE_W'(1));
		sts.p0_lt_n     = (p0_q < n_eff);
		sts.out_free    = !out_valid_q || res_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= ceu_pkg::SIZE_W'(1);
			idx_q  <= '0;
			last_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				size_q <= cfg_wr_data;
			end
			case (cmd.idx_op)
				ceu_pkg::IDX_CLR:    idx_q <= '0;
				ceu_pkg::IDX_LASTM1: idx_q <= last_q - IW'(1);
				ceu_pkg::IDX_INC:    idx_q <= idx_q + IW'(1);
				ceu_pkg::IDX_DEC:    idx_q <= idx_q - IW'(1);
				default:             idx_q <= idx_q;
			endcase
			if (cmd.set_last) begin
				last_q <= idx_q;
			end
		end
	end

	// The refill writes one place past the index and advances it in the same cycle.
	always_comb begin
		wr_addr  = cmd.refill_wr ? (idx_q + IW'(1)) : idx_q;
		mem_we   = cmd.fill_wr || cmd.inc_wr || cmd.refill_wr;
		parts_wd = ceu_pkg::VAL_W'(1);
		pref_wd  = ps_q + ceu_pkg::SIZE_W'(1);
		if (cmd.fill_wr) begin
			pref_wd = ceu_pkg::SIZE_W'(idx_ext + CW'(1));
		end else if (cmd.inc_wr) begin
			parts_wd = parts_rd_q + ceu_pkg::VAL_W'(1);
			pref_wd  = pref_rd_q + ceu_pkg::SIZE_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			parts_mem[wr_addr] <= parts_wd;
			pref_mem[wr_addr]  <= pref_wd;
		end
		parts_rd_q <= parts_mem[idx_q];
		pref_rd_q  <= pref_mem[idx_q];
		if (cmd.inc_wr || cmd.refill_wr) begin
			ps_q <= pref_wd;
		end
		if ((cmd.fill_wr || cmd.inc_wr) && (idx_q == '0)) begin
			p0_q <= parts_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_part || cmd.out_exh) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_part) begin
			res_value     <= parts_rd_q;
			res_position  <= ceu_pkg::POS_W'(idx_q);
			res_last      <= (idx_q == last_q);
			res_final     <= cmd.final_flag;
			res_exhausted <= 1'b0;
		end else if (cmd.out_exh) begin
			res_value     <= '0;
			res_position  <= '0;
			res_last      <= 1'b1;
			res_final     <= 1'b0;
			res_exhausted <= 1'b1;
		end
	end

	assign res_valid = out_valid_q;

endmodule

// ===== hw/rtl/ceu_ctrl.sv =====
// Controller of the composition enumerator: sequences fill, walk-back,
// refill and emission. Depends on ceu_pkg.
`timescale 1ns / 1ps

module ceu_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_restart,
	output logic          req_ready,
	input  logic          cfg_wr_en,
	input  ceu_pkg::sts_t sts,
	output ceu_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_FILL     = 3'd1;
	localparam logic [2:0] ST_WALK_RD  = 3'd2;
	localparam logic [2:0] ST_WALK_CHK = 3'd3;
	localparam logic [2:0] ST_REFILL   = 3'd4;
	localparam logic [2:0] ST_EMIT_RD  = 3'd5;
	localparam logic [2:0] ST_EMIT_WR  = 3'd6;
	localparam logic [2:0] ST_EXH      = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       started_q;
	logic       started_d;
	logic       more_q;
	logic       more_d;
	logic       started_eff;
	logic       more_eff;

	assign req_ready = (state_q == ST_IDLE);

	// A restart acts on the flags before the request is judged.
	assign started_eff = req_restart ? 1'b0 : started_q;
	assign more_eff    = req_restart ? 1'b1 : more_q;

	always_comb begin
		state_d   = state_q;
		started_d = started_q;
		more_d    = more_q;
		cmd       = '0;
		cmd.idx_op = ceu_pkg::IDX_HOLD;
		cmd.final_flag = !more_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					started_d = started_eff;
					if (!more_eff || sts.n_zero) begin
						more_d  = 1'b0;
						state_d = ST_EXH;
					end else if (!started_eff) begin
						started_d  = 1'b1;
						cmd.idx_op = ceu_pkg::IDX_CLR;
						state_d    = ST_FILL;
					end else if (sts.last_zero) begin
						more_d  = 1'b0;
						state_d = ST_EXH;
					end else begin
						cmd.idx_op = ceu_pkg::IDX_LASTM1;
						state_d    = ST_WALK_RD;
					end
				end
			end
			ST_FILL: begin
				cmd.fill_wr = 1'b1;
				if (sts.fill_end) begin
					cmd.set_last = 1'b1;
					cmd.idx_op   = ceu_pkg::IDX_CLR;
					more_d       = sts.n_gt1;
					state_d      = ST_EMIT_RD;
				end else begin
					cmd.idx_op = ceu_pkg::IDX_INC;
				end
			end
			ST_WALK_RD: begin
				state_d = ST_WALK_CHK;
			end
			ST_WALK_CHK: begin
				if (sts.pref_lt_n) begin
					cmd.inc_wr = 1'b1;
					state_d    = ST_REFILL;
				end else if (sts.idx_zero) begin
					more_d  = 1'b0;
					state_d = ST_EXH;
				end else begin
					cmd.idx_op = ceu_pkg::IDX_DEC;
					state_d    = ST_WALK_RD;
				end
			end
			ST_REFILL: begin
				if (sts.refill_go) begin
					cmd.refill_wr = 1'b1;
					cmd.idx_op    = ceu_pkg::IDX_INC;
				end else begin
					cmd.set_last = 1'b1;
					cmd.idx_op   = ceu_pkg::IDX_CLR;
					more_d       = sts.p0_lt_n;
					state_d      = ST_EMIT_RD;
				end
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_WR;
			end
			ST_EMIT_WR: begin
				if (sts.out_free) begin
					cmd.out_part = 1'b1;
					if (sts.idx_at_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.idx_op = ceu_pkg::IDX_INC;
						state_d    = ST_EMIT_RD;
					end
				end
			end
			ST_EXH: begin
				if (sts.out_free) begin
					cmd.out_exh = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// A size write restarts the listing; a zero size is caught on the next request.
		if (cfg_wr_en) begin
			started_d = 1'b0;
			more_d    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			started_q <= 1'b0;
			more_q    <= 1'b1;
		end else begin
			state_q   <= state_d;
			started_q <= started_d;
			more_q    <= more_d;
		end
	end

endmodule

// ===== hw/rtl/composition_enumerator_unit.sv =====
// Composition enumerator: one request at a time, taken the cycle after its last word loads.
// A first composition is filled and then emitted; a following one walks back over positions,
// refills parts and then emits them; each part costs a memory read state and an output state,
// and the output state waits while the result register is full and not being taken.
// An exhausted request goes to the exhausted state, which loads its word once the output register is free.
// Reset clears control state and sets the size to 1; the part memories are not cleared.
`timescale 1ns / 1ps

module composition_enumerator_unit #(
	parameter int MAX_SIZE = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [ceu_pkg::SIZE_W-1:0] cfg_wr_data,
	ceu_req_if.sink                    req,
	ceu_res_if.source                  res
);

	ceu_pkg::cmd_t cmd;
	ceu_pkg::sts_t sts;

	ceu_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_restart (req.restart),
		.req_ready   (req.ready),
		.cfg_wr_en   (cfg_wr_en),
		.sts         (sts),
		.cmd         (cmd)
	);

	ceu_dpath #(
		.MAX_SIZE (MAX_SIZE)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.cmd           (cmd),
		.sts           (sts),
		.res_valid     (res.valid),
		.res_ready     (res.ready),
		.res_value     (res.part_value),
		.res_position  (res.part_position),
		.res_last      (res.last_part),
		.res_final     (res.final_composition),
		.res_exhausted (res.exhausted)
	);

endmodule

// ===== tb/ceu_checker.sv =====
// Checker for the composition enumerator: watches the configuration, request
// and result ports, predicts every composition and compares each word.
// Depends on ceu_pkg and on the ceu_req_if and ceu_res_if interfaces.
`timescale 1ns / 1ps

module ceu_checker #(
	parameter int MAX_SIZE = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [ceu_pkg::SIZE_W-1:0] cfg_wr_data,
	ceu_req_if                         req,
	ceu_res_if                         res,
	output int                         mismatches,
	output int                         words_pending
);

	typedef struct packed {
		logic [ceu_pkg::VAL_W-1:0] value;
		logic [ceu_pkg::POS_W-1:0] position;
		logic                      last_part;
		logic                      final_comp;
		logic                      exhausted;
	} part_word_t;

	part_word_t                 expected_parts[$];
	logic [ceu_pkg::SIZE_W-1:0] size_reg;
	logic [ceu_pkg::VAL_W-1:0]  parts [MAX_SIZE];
	logic [ceu_pkg::VAL_W-1:0]  sums [MAX_SIZE];
	logic [ceu_pkg::POS_W-1:0]  last_idx;
	logic                       more_left;
	logic                       started;
	int                         words_seen;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic int clamped_size();
		return (int'(size_reg) > MAX_SIZE) ? MAX_SIZE : int'(size_reg);
	endfunction

	function automatic void push_exhausted();
		part_word_t w;
		w = '0;
		w.last_part = 1'b1;
		w.exhausted = 1'b1;
		expected_parts.push_back(w);
	endfunction

	// Walks back to the last position whose prefix sum is below n, bumps that
	// part and refills the tail with ones. Returns 0 if nothing can grow.
	function automatic bit advance_parts(input int n);
		int  j;
		bit  found;
		j = int'(last_idx);
		found = 1'b0;
		while (j > 0 && !found) begin
			j--;
			if (int'(sums[j]) < n)
				found = 1'b1;
		end
		if (!found)
			return 1'b0;
		parts[j] = parts[j] + 1'b1;
		sums[j] = sums[j] + 1'b1;
		while (int'(sums[j]) < n && j + 1 < n) begin
			j++;
			parts[j] = ceu_pkg::VAL_W'(1);
			sums[j] = sums[j - 1] + 1'b1;
		end
		last_idx = ceu_pkg::POS_W'(j);
		return 1'b1;
	endfunction

	function automatic void predict_composition(input logic restart_flag);
		int         n;
		int         i;
		part_word_t w;
		n = clamped_size();
		if (restart_flag) begin
			started = 1'b0;
			more_left = (n != 0);
		end
		if (!more_left || n == 0) begin
			more_left = 1'b0;
			push_exhausted();
			return;
		end
		if (!started) begin
			for (i = 0; i < n; i++) begin
				parts[i] = ceu_pkg::VAL_W'(1);
				sums[i] = ceu_pkg::VAL_W'(i + 1);
			end
			last_idx = ceu_pkg::POS_W'(n - 1);
			started = 1'b1;
		end else if (!advance_parts(n)) begin
			more_left = 1'b0;
			push_exhausted();
			return;
		end
		more_left = int'(parts[0]) < n;
		for (i = 0; i <= int'(last_idx) && i < MAX_SIZE; i++) begin
			w.value = parts[i];
			w.position = ceu_pkg::POS_W'(i);
			w.last_part = (i == int'(last_idx));
			w.final_comp = !more_left;
			w.exhausted = 1'b0;
			expected_parts.push_back(w);
		end
	endfunction

	always @(posedge clk) begin : monitor
		int         k;
		part_word_t want;
		if (!arst_n) begin
			expected_parts.delete();
			for (k = 0; k < MAX_SIZE; k++) begin
				parts[k] = '0;
				sums[k] = '0;
			end
			size_reg = ceu_pkg::SIZE_W'(1);
			last_idx = '0;
			more_left = 1'b1;
			started = 1'b0;
			words_seen = 0;
			mismatches = 0;
			words_pending = 0;
		end else begin
			if (cfg_wr_en === 1'b1) begin
				size_reg = cfg_wr_data;
				started = 1'b0;
				more_left = clamped_size() != 0;
			end
			// A word leaving is checked before a request arriving on the same edge.
			if (res.valid === 1'b1 && res.ready === 1'b1) begin
				if (expected_parts.size() == 0) begin
					report_mismatch($sformatf(
						"word %0d unexpected: value %0d pos %0d last %b final %b exh %b",
						words_seen, res.part_value, res.part_position, res.last_part,
						res.final_composition, res.exhausted));
				end else begin
					want = expected_parts.pop_front();
					if (res.part_value !== want.value || res.part_position !== want.position
						|| res.last_part !== want.last_part
						|| res.final_composition !== want.final_comp
						|| res.exhausted !== want.exhausted) begin
						report_mismatch($sformatf(
							{"word %0d: got value %0d pos %0d last %b final %b exh %b, ",
							"want value %0d pos %0d last %b final %b exh %b"},
							words_seen, res.part_value, res.part_position, res.last_part,
							res.final_composition, res.exhausted, want.value,
							want.position, want.last_part, want.final_comp,
							want.exhausted));
					end
				end
				words_seen++;
			end
			if (req.valid === 1'b1 && req.ready === 1'b1)
				predict_composition(req.restart);
			words_pending = expected_parts.size();
		end
	end

endmodule

// ===== tb/tb_composition_enumerator_unit.sv =====
// Testbench top for the composition enumerator: clock, reset, configuration
// writes, bursty requests and a stalling result sink; ceu_checker does the checking.
// Depends on ceu_pkg, the channel interfaces, composition_enumerator_unit and ceu_checker.
`timescale 1ns / 1ps

module tb_composition_enumerator_unit;

	localparam int MAX_SIZE     = 16;
	localparam int RANDOM_ITEMS = 330;
	localparam int LONG_HOLD    = 400;
	localparam int SETTLE       = 8;

	typedef enum int {
		RX_FREE,
		RX_RANDOM,
		RX_SPARSE
	} rx_mode_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_wr_en;
	logic [ceu_pkg::SIZE_W-1:0] cfg_wr_data;
	int                         mismatches;
	int                         words_pending;
	int                         items_sent;
	int                         burst_left;
	int                         holds_asked;

	ceu_req_if req_ch();
	ceu_res_if res_ch();

	composition_enumerator_unit #(
		.MAX_SIZE(MAX_SIZE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req(req_ch),
		.res(res_ch)
	);

	ceu_checker #(
		.MAX_SIZE(MAX_SIZE)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req(req_ch),
		.res(res_ch),
		.mismatches(mismatches),
		.words_pending(words_pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Offers one request and waits until it is taken; bursts end in a random gap.
	task automatic send_request(input logic restart_flag);
		int gap;
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.restart <= restart_flag;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 7);
			if (gap > 0) begin
				@(negedge clk);
				req_ch.valid <= 1'b0;
				req_ch.restart <= 1'($urandom);
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (words_pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_size(input logic [ceu_pkg::SIZE_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin : receiver
		int       hold_left;
		int       seg_left;
		int       holds_done;
		rx_mode_t mode;
		res_ch.ready = 1'b0;
		hold_left = 0;
		seg_left = 0;
		holds_done = 0;
		mode = RX_FREE;
		forever begin
			@(negedge clk);
			if (holds_done != holds_asked) begin
				holds_done = holds_asked;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 2));
					seg_left = $urandom_range(4, 60);
				end
				seg_left--;
				case (mode)
					RX_FREE: res_ch.ready <= 1'b1;
					RX_RANDOM: res_ch.ready <= 1'($urandom);
					default: res_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		int size;
		int eff;
		int count;
		int first_random;
		req_ch.valid = 1'b0;
		req_ch.restart = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		arst_n = 1'b0;
		items_sent = 0;
		burst_left = 1;
		holds_asked = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Size 1 from reset: one composition, then exhausted until restarted.
		send_request(1'b0);
		send_request(1'b0);
		send_request(1'b1);
		send_request(1'b0);
		wait_idle();

		// Size zero gives only exhausted words.
		write_size(0);
		send_request(1'b0);
		send_request(1'b1);
		wait_idle();

		// Size 3 run past its end, then a restart and one more request.
		write_size(3);
		repeat (5) send_request(1'b0);
		send_request(1'b1);
		send_request(1'b0);
		wait_idle();

		// An oversized setting is clamped; the sink holds off meanwhile so the
		// request side backs up.
		write_size(31);
		holds_asked++;
		repeat (4) send_request(1'b0);
		wait_idle();

		write_size(17);
		send_request(1'b0);
		wait_idle();

		write_size(16);
		send_request(1'b1);
		send_request(1'b0);
		wait_idle();

		write_size(2);
		repeat (3) send_request(1'b0);
		wait_idle();

		first_random = items_sent;
		while (items_sent - first_random < RANDOM_ITEMS) begin
			case ($urandom_range(0, 15))
				0: size = 0;
				10, 11, 12: size = $urandom_range(7, 16);
				13: size = $urandom_range(17, 31);
				14, 15: size = $urandom_range(1, 4);
				default: size = $urandom_range(1, 6);
			endcase
			write_size(ceu_pkg::SIZE_W'(size));
			eff = (size > MAX_SIZE) ? MAX_SIZE : size;
			// Small sizes get one request per composition plus up to three more.
			if (eff == 0)
				count = $urandom_range(1, 4);
			else if (eff <= 6)
				count = (1 << (eff - 1)) + $urandom_range(0, 3);
			else
				count = $urandom_range(3, 12);
			repeat (count) send_request($urandom_range(0, 19) == 0);
			wait_idle();
		end

		wait_idle();
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/ceu_pkg.sv
hw/rtl/ceu_req_if.sv
hw/rtl/ceu_res_if.sv
hw/rtl/ceu_dpath.sv
hw/rtl/ceu_ctrl.sv
hw/rtl/composition_enumerator_unit.sv
tb/ceu_checker.sv
tb/tb_composition_enumerator_unit.sv
